/* sv/mprc_pkg.sv */
package mprc_pkg;

  localparam int unsigned RULES = 16;
  localparam int unsigned IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int unsigned CNT_W = $clog2(RULES + 1);

  localparam logic [7:0] PROTO_ICMP = 8'd1;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_CLASSIFY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_ENABLED  = 2'd1,
    VERDICT_DISABLED = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] address;
    logic [31:0] mask;
    logic [15:0] port;
    logic        local_side;
    logic        enabled;
  } rule_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] address;
    logic [15:0] port;
  } pkt_t;

  typedef struct packed {
    logic hit;
    logic same;
  } eval_t;

endpackage

/* sv/mprc_if.sv */
interface mprc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  protocol;
  logic [31:0] address;
  logic [31:0] address_mask;
  logic [15:0] port_number;
  logic        use_local_side;
  logic        rule_enabled;
  logic [31:0] local_address;
  logic [15:0] host_port;

  modport source (
    output valid, opcode, protocol, address, address_mask, port_number,
           use_local_side, rule_enabled, local_address, host_port,
    input  ready
  );
  modport sink (
    input  valid, opcode, protocol, address, address_mask, port_number,
           use_local_side, rule_enabled, local_address, host_port,
    output ready
  );
endinterface

interface mprc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       rule_added;

  modport source (output valid, verdict, rule_added, input ready);
  modport sink (input valid, verdict, rule_added, output ready);
endinterface

/* sv/masked_packet_rule_classifier_core.sv */
// Channel  Dir  Transfer when        Payload
// in_i     in   valid & ready        opcode, protocol, address, address_mask, port_number,
//                                    use_local_side, rule_enabled, local_address, host_port
// out_o    out  valid & ready        verdict, rule_added
//
// Add and classify walk the n stored rules (at most RULES), one read of the rule memory
// per cycle, with the compare in the cycle after the read.
// Classify stops at the first hit. Clear and unused opcodes skip the walk.
// Reset empties the table at once; no clearing pass.
// A held result in the output register does not block the next input transfer.
module masked_packet_rule_classifier_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  mprc_in_if.sink          in_i,
  mprc_out_if.source       out_o
);
  import mprc_pkg::*;

  rule_t            mem [RULES];
  rule_t            rd_data_q;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             rd_valid_q, rd_valid_d;
  logic             rd_last_q, rd_last_d;
  logic             dup_q, dup_d;
  logic [1:0]       verdict_q, verdict_d;
  logic [1:0]       op_q;
  rule_t            cand_q;
  logic [31:0]      laddr_q;
  logic [15:0]      lport_q;
  pkt_t             pkt_q, pkt_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_verdict_q;
  logic             out_added_q;

  logic             accept;
  logic             issue;
  logic             load_out;
  logic             add_ok;
  logic             wr_en;
  logic [CNT_W-1:0] visit;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             op_walks;
  pkt_t             pkt_next;
  eval_t            eval;

  mprc_rule_eval u_eval (
    .rule_i          (rd_data_q),
    .pkt_i           (pkt_q),
    .local_address_i (laddr_q),
    .host_port_i     (lport_q),
    .cand_i          (cand_q),
    .pkt_o           (pkt_next),
    .eval_o          (eval)
  );

  assign accept   = in_i.valid && in_i.ready;
  assign op_walks = (in_i.opcode == OP_ADD) || (in_i.opcode == OP_CLASSIFY);
  assign issue    = (state_q == S_WALK) && (k_q != count_q);
  assign visit    = (k_q == '0) ? '0 : (count_q - k_q);
  assign rd_idx   = visit[IDX_W-1:0];
  assign wr_idx   = count_q[IDX_W-1:0];
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign add_ok   = (op_q == OP_ADD) && !dup_q && (count_q < CNT_W'(RULES));
  assign wr_en    = load_out && add_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= cand_q;
    end
    rd_data_q <= mem[rd_idx];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (op_walks && count_q != '0) ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (rd_valid_q && ((op_q == OP_CLASSIFY && eval.hit) || rd_last_q)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == S_IDLE);
    count_d    = count_q;
    k_d        = k_q;
    rd_valid_d = issue;
    rd_last_d  = issue && ((k_q + CNT_W'(1)) == count_q);
    dup_d      = dup_q;
    verdict_d  = verdict_q;
    pkt_d      = pkt_q;
    if (accept) begin
      k_d            = '0;
      dup_d          = 1'b0;
      verdict_d      = VERDICT_NONE;
      pkt_d.protocol = in_i.protocol;
      pkt_d.address  = in_i.address;
      pkt_d.port     = in_i.port_number;
      if (in_i.opcode == OP_CLEAR) begin
        count_d = '0;
      end
    end
    if (issue) begin
      k_d = k_q + CNT_W'(1);
    end
    if (state_q == S_WALK && rd_valid_q) begin
      pkt_d = pkt_next;
      if (eval.same) begin
        dup_d = 1'b1;
      end
      if (op_q == OP_CLASSIFY && eval.hit) begin
        verdict_d = rd_data_q.enabled ? VERDICT_ENABLED : VERDICT_DISABLED;
      end
    end
    if (wr_en) begin
      count_d = count_q + CNT_W'(1);
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      rd_valid_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      rd_valid_q  <= rd_valid_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dup_q     <= dup_d;
    verdict_q <= verdict_d;
    pkt_q     <= pkt_d;
    if (accept) begin
      op_q              <= in_i.opcode;
      cand_q.protocol   <= in_i.protocol;
      cand_q.address    <= in_i.address;
      cand_q.mask       <= in_i.address_mask;
      cand_q.port       <= in_i.port_number;
      cand_q.local_side <= in_i.use_local_side;
      cand_q.enabled    <= in_i.rule_enabled;
      laddr_q           <= in_i.local_address;
      lport_q           <= in_i.host_port;
    end
    if (load_out) begin
      out_verdict_q <= (op_q == OP_CLASSIFY) ? verdict_q : VERDICT_NONE;
      out_added_q   <= add_ok;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.verdict    = out_verdict_q;
  assign out_o.rule_added = out_added_q;

endmodule

/* sv/mprc_rule_eval.sv */
module mprc_rule_eval (
  input  mprc_pkg::rule_t rule_i,
  input  mprc_pkg::pkt_t  pkt_i,
  input  logic [31:0]     local_address_i,
  input  logic [15:0]     host_port_i,
  input  mprc_pkg::rule_t cand_i,
  output mprc_pkg::pkt_t  pkt_o,
  output mprc_pkg::eval_t eval_o
);
  import mprc_pkg::*;

  logic has_addr;
  logic has_port;
  logic addr_eq;
  logic port_eq;
  logic proto_eq;
  logic dup_addr;
  logic dup_port;
  logic dup_proto;

  always_comb begin
    pkt_o = pkt_i;
    if (rule_i.local_side) begin
      pkt_o.address = local_address_i;
      pkt_o.port    = host_port_i;
    end
    if (pkt_i.protocol == PROTO_ICMP) begin
      pkt_o.protocol = rule_i.protocol;
    end
  end

  assign has_addr = (rule_i.address != 32'd0);
  assign has_port = (rule_i.port != 16'd0);
  assign addr_eq  = (((pkt_o.address ^ rule_i.address) & rule_i.mask) == 32'd0);
  assign port_eq  = (pkt_o.port == rule_i.port);
  assign proto_eq = (pkt_o.protocol == rule_i.protocol);

  assign dup_addr  = (cand_i.address == rule_i.address) && (cand_i.mask == rule_i.mask);
  assign dup_port  = (cand_i.port == rule_i.port);
  assign dup_proto = (cand_i.protocol == rule_i.protocol);

  always_comb begin
    eval_o = '0;
    priority if (has_addr && has_port) begin
      eval_o.hit  = proto_eq && addr_eq && port_eq;
      eval_o.same = dup_proto && dup_addr && dup_port;
    end else if (has_addr) begin
      eval_o.hit  = proto_eq && addr_eq;
      eval_o.same = dup_proto && dup_addr;
    end else if (has_port) begin
      eval_o.hit  = proto_eq && port_eq;
      eval_o.same = dup_proto && dup_port;
    end else begin
      eval_o.hit  = 1'b0;
      eval_o.same = 1'b0;
    end
  end

endmodule
